// ===== src/ptcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcp_pkg: shared widths, latencies and types
// Constants and types used by the closest-point pipeline and its sub-units.
// ----------------------------------------------------------------------------
`default_nettype none
package ptcp_pkg;
    localparam int COORD_BITS = 32;
    localparam int SFRAC      = COORD_BITS + 2;
    localparam int EW         = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EW;
    localparam int DOT_W      = PROD_W + 2;
    localparam int SUM_W      = DOT_W + 2;
    localparam int MIN_W      = DOT_W + 1;
    localparam int CHUNK      = (MIN_W + 2) / 3;
    localparam int WIDE_W     = 6 * CHUNK + 2;
    localparam int Q_W        = SFRAC + 1;
    localparam int SUMSQ_W    = PROD_W + 2;
    localparam int ROOT_IN_W  = 2 * COORD_BITS;

    localparam logic [Q_W-1:0] ONE_FR = Q_W'(1) << SFRAC;

    localparam int LAT_MUL   = 4;
    localparam int LAT_FRONT = 4 + LAT_MUL;
    localparam int LAT_DIV   = SFRAC + 1;
    localparam int LAT_SQRT  = COORD_BITS + 1;
    localparam int LAT_TOTAL = LAT_FRONT + 2 + LAT_DIV + 6 + LAT_SQRT + 1;

    typedef logic [2:0][EW-1:0] t_vec3;

    typedef struct packed {
        t_vec3 v0;
        t_vec3 e0;
        t_vec3 e1;
        t_vec3 q;
    } t_geo;

    typedef struct packed {
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] d;
        logic signed [DOT_W-1:0] e;
    } t_dots;

    typedef struct packed {
        t_geo                     geo;
        t_dots                    dots;
        logic signed [WIDE_W-1:0] det;
        logic signed [WIDE_W-1:0] sn;
        logic signed [WIDE_W-1:0] tn;
    } t_front;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_DIV,
        SRC_COMP
    } t_src;

    typedef struct packed {
        t_src src_s;
        t_src src_t;
        logic degen;
    } t_ctl;
endpackage
`default_nettype wire

// ===== src/ptcp_mul.sv =====
// ----------------------------------------------------------------------------
// ptcp_mul: pipelined wide signed multiplier
// Sign and magnitude form, nine partial products, summed and re-signed.
// ----------------------------------------------------------------------------
`default_nettype none
module ptcp_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [ptcp_pkg::MIN_W-1:0]     i_a,
    input  wire logic signed [ptcp_pkg::MIN_W-1:0]     i_b,
    output logic signed [ptcp_pkg::WIDE_W-1:0]         o_p
);
    localparam int CH    = ptcp_pkg::CHUNK;
    localparam int MAG_W = 3 * CH;

    logic [ptcp_pkg::MIN_W-1:0] n_abs_a, n_abs_b;
    logic [MAG_W-1:0]           r_ma, r_mb;
    logic                       r_neg1, r_neg2, r_neg3;
    logic [2*CH-1:0]            r_pp [3][3];
    logic [2*MAG_W-1:0]         n_mag, r_mag;
    logic signed [ptcp_pkg::WIDE_W-1:0] n_ext, r_p;

    always_comb begin
        n_abs_a = i_a[ptcp_pkg::MIN_W-1] ? $unsigned(-i_a) : $unsigned(i_a);
        n_abs_b = i_b[ptcp_pkg::MIN_W-1] ? $unsigned(-i_b) : $unsigned(i_b);
    end

    always_comb begin
        n_mag = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_mag = n_mag + ((2*MAG_W)'(r_pp[i][j]) << ((i + j) * CH));
            end
        end
    end

    assign n_ext = $signed(ptcp_pkg::WIDE_W'(r_mag));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[ptcp_pkg::MIN_W-1] ^ i_b[ptcp_pkg::MIN_W-1];
            r_ma   <= MAG_W'(n_abs_a);
            r_mb   <= MAG_W'(n_abs_b);
            r_neg2 <= r_neg1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= r_ma[i*CH +: CH] * r_mb[j*CH +: CH];
                end
            end
            r_neg3 <= r_neg2;
            r_mag  <= n_mag;
            r_p    <= r_neg3 ? -n_ext : n_ext;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== src/ptcp_front.sv =====
// ----------------------------------------------------------------------------
// ptcp_front: edges, dot products, determinant and unclamped numerators
// Eight register stages from the accepted item to det, s' and t'.
// ----------------------------------------------------------------------------
`default_nettype none
module ptcp_front (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_en,
    input  wire logic [2:0][ptcp_pkg::COORD_BITS-1:0]     i_v0,
    input  wire logic [2:0][ptcp_pkg::COORD_BITS-1:0]     i_v1,
    input  wire logic [2:0][ptcp_pkg::COORD_BITS-1:0]     i_v2,
    input  wire logic [2:0][ptcp_pkg::COORD_BITS-1:0]     i_q,
    output ptcp_pkg::t_front                              o_front
);
    localparam int EW = ptcp_pkg::EW;
    localparam int MW = ptcp_pkg::MIN_W;

    ptcp_pkg::t_geo n_geo;
    logic signed [EW-1:0] n_dv [3];
    logic signed [EW-1:0] r_dv [3];
    ptcp_pkg::t_geo r_geo_d [ptcp_pkg::LAT_FRONT];
    logic signed [ptcp_pkg::PROD_W-1:0] r_pr [15];
    ptcp_pkg::t_dots n_dots;
    ptcp_pkg::t_dots r_dots_d [ptcp_pkg::LAT_FRONT-2];
    logic signed [ptcp_pkg::WIDE_W-1:0] p_ac, p_bb, p_be, p_cd, p_bd, p_ae;
    logic signed [ptcp_pkg::WIDE_W-1:0] r_det, r_sn, r_tn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_geo.v0[k] = EW'($signed(i_v0[k]));
            n_geo.e0[k] = EW'($signed(i_v1[k])) - EW'($signed(i_v0[k]));
            n_geo.e1[k] = EW'($signed(i_v2[k])) - EW'($signed(i_v0[k]));
            n_geo.q[k]  = EW'($signed(i_q[k]));
            n_dv[k]     = EW'($signed(i_v0[k])) - EW'($signed(i_q[k]));
        end
    end

    // Dot products from the three axis products of each pair.
    always_comb begin
        n_dots.a = ptcp_pkg::DOT_W'(r_pr[0])  + ptcp_pkg::DOT_W'(r_pr[1])
                 + ptcp_pkg::DOT_W'(r_pr[2]);
        n_dots.b = ptcp_pkg::DOT_W'(r_pr[3])  + ptcp_pkg::DOT_W'(r_pr[4])
                 + ptcp_pkg::DOT_W'(r_pr[5]);
        n_dots.c = ptcp_pkg::DOT_W'(r_pr[6])  + ptcp_pkg::DOT_W'(r_pr[7])
                 + ptcp_pkg::DOT_W'(r_pr[8]);
        n_dots.d = ptcp_pkg::DOT_W'(r_pr[9])  + ptcp_pkg::DOT_W'(r_pr[10])
                 + ptcp_pkg::DOT_W'(r_pr[11]);
        n_dots.e = ptcp_pkg::DOT_W'(r_pr[12]) + ptcp_pkg::DOT_W'(r_pr[13])
                 + ptcp_pkg::DOT_W'(r_pr[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo_d[0] <= n_geo;
            for (int k = 0; k < 3; k++) begin
                r_dv[k]       <= n_dv[k];
                r_pr[k]       <= $signed(r_geo_d[0].e0[k]) * $signed(r_geo_d[0].e0[k]);
                r_pr[3 + k]   <= $signed(r_geo_d[0].e0[k]) * $signed(r_geo_d[0].e1[k]);
                r_pr[6 + k]   <= $signed(r_geo_d[0].e1[k]) * $signed(r_geo_d[0].e1[k]);
                r_pr[9 + k]   <= $signed(r_geo_d[0].e0[k]) * r_dv[k];
                r_pr[12 + k]  <= $signed(r_geo_d[0].e1[k]) * r_dv[k];
            end
            for (int i = 1; i < ptcp_pkg::LAT_FRONT; i++) begin
                r_geo_d[i] <= r_geo_d[i-1];
            end
            r_dots_d[0] <= n_dots;
            for (int i = 1; i < ptcp_pkg::LAT_FRONT - 2; i++) begin
                r_dots_d[i] <= r_dots_d[i-1];
            end
            r_det <= p_ac - p_bb;
            r_sn  <= p_be - p_cd;
            r_tn  <= p_bd - p_ae;
        end
    end

    ptcp_mul u_mul_ac (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].a)), .i_b(MW'(r_dots_d[0].c)),
                       .o_p(p_ac));
    ptcp_mul u_mul_bb (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].b)), .i_b(MW'(r_dots_d[0].b)),
                       .o_p(p_bb));
    ptcp_mul u_mul_be (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].b)), .i_b(MW'(r_dots_d[0].e)),
                       .o_p(p_be));
    ptcp_mul u_mul_cd (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].c)), .i_b(MW'(r_dots_d[0].d)),
                       .o_p(p_cd));
    ptcp_mul u_mul_bd (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].b)), .i_b(MW'(r_dots_d[0].d)),
                       .o_p(p_bd));
    ptcp_mul u_mul_ae (.i_clk, .i_en, .i_a(MW'(r_dots_d[0].a)), .i_b(MW'(r_dots_d[0].e)),
                       .o_p(p_ae));

    always_comb begin
        o_front.geo  = r_geo_d[ptcp_pkg::LAT_FRONT-1];
        o_front.dots = r_dots_d[ptcp_pkg::LAT_FRONT-3];
        o_front.det  = r_det;
        o_front.sn   = r_sn;
        o_front.tn   = r_tn;
    end
endmodule
`default_nettype wire

// ===== src/ptcp_div.sv =====
// ----------------------------------------------------------------------------
// ptcp_div: pipelined clamped fraction divider
// Gives num/den clamped to [0,1] with SFRAC fraction bits, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ptcp_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [ptcp_pkg::WIDE_W-1:0]    i_num,
    input  wire logic signed [ptcp_pkg::WIDE_W-1:0]    i_den,
    output logic [ptcp_pkg::Q_W-1:0]                   o_q
);
    localparam int W  = ptcp_pkg::WIDE_W;
    localparam int SF = ptcp_pkg::SFRAC;

    logic [W-1:0]  r_rem  [SF+1];
    logic [W-1:0]  r_den  [SF+1];
    logic [SF-1:0] r_q    [SF+1];
    logic          r_zero [SF+1];
    logic          r_one  [SF+1];
    logic [W:0]    n_rem2 [SF+1];
    logic          n_ge   [SF+1];

    always_comb begin
        n_rem2[0] = '0;
        n_ge[0]   = 1'b0;
        for (int i = 1; i <= SF; i++) begin
            n_rem2[i] = {r_rem[i-1], 1'b0};
            n_ge[i]   = n_rem2[i] >= {1'b0, r_den[i-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_num[W-1] || (i_num == '0);
            r_one[0]  <= !(i_num < i_den);
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            for (int i = 1; i <= SF; i++) begin
                r_zero[i] <= r_zero[i-1];
                r_one[i]  <= r_one[i-1];
                r_den[i]  <= r_den[i-1];
                r_rem[i]  <= W'(n_ge[i] ? n_rem2[i] - {1'b0, r_den[i-1]} : n_rem2[i]);
                r_q[i]    <= {r_q[i-1][SF-2:0], n_ge[i]};
            end
        end
    end

    assign o_q = r_zero[SF] ? '0 :
                 r_one[SF]  ? ptcp_pkg::ONE_FR : ptcp_pkg::Q_W'(r_q[SF]);
endmodule
`default_nettype wire

// ===== src/ptcp_sqrt.sv =====
// ----------------------------------------------------------------------------
// ptcp_sqrt: pipelined integer square root with saturation
// One result bit a stage; a sum of 2^(2*COORD_BITS) or more saturates.
// ----------------------------------------------------------------------------
`default_nettype none
module ptcp_sqrt (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [ptcp_pkg::SUMSQ_W-1:0]          i_sum,
    output logic [ptcp_pkg::COORD_BITS-1:0]            o_root
);
    localparam int N  = ptcp_pkg::COORD_BITS;
    localparam int RW = ptcp_pkg::ROOT_IN_W;

    logic [RW-1:0] r_op  [N+1];
    logic [RW-1:0] r_res [N+1];
    logic          r_sat [N+1];
    logic [RW-1:0] n_bit [N+1];
    logic [RW-1:0] n_try [N+1];
    logic          n_ge  [N+1];

    always_comb begin
        n_bit[0] = '0;
        n_try[0] = '0;
        n_ge[0]  = 1'b0;
        for (int j = 1; j <= N; j++) begin
            n_bit[j] = RW'(1) << (2 * (N - j));
            n_try[j] = r_res[j-1] + n_bit[j];
            n_ge[j]  = r_op[j-1] >= n_try[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= |i_sum[ptcp_pkg::SUMSQ_W-1:RW];
            r_op[0]  <= i_sum[RW-1:0];
            r_res[0] <= '0;
            for (int j = 1; j <= N; j++) begin
                r_sat[j] <= r_sat[j-1];
                r_op[j]  <= n_ge[j] ? r_op[j-1] - n_try[j] : r_op[j-1];
                r_res[j] <= n_ge[j] ? (r_res[j-1] >> 1) + n_bit[j] : r_res[j-1] >> 1;
            end
        end
    end

    assign o_root = r_sat[N] ? '1 : r_res[N][N-1:0];
endmodule
`default_nettype wire

// ===== src/point_triangle_closest_point.sv =====
// ----------------------------------------------------------------------------
// point_triangle_closest_point: closest point of a triangle to a query point
// Region-sorted barycentric clamp with exact wide arithmetic, fully pipelined.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_valid / o_ready) carries one item: three
// vertices and a query point, signed Q16.16. The output channel (o_valid /
// i_ready) returns one item per input item, in order: the closest point on
// the triangle, its distance to the query (unsigned Q16.16, saturating) and a
// flag for a degenerate triangle.
// Throughput is one item per cycle while the receiver does not stall. The
// latency is set by the pipeline depth, the longest parts being the 35-stage
// fraction dividers and the 33-stage square root.
// The whole pipeline advances together. When a finished item waits at the
// output and the receiver holds i_ready low, every stage holds, o_ready
// drops and nothing is lost or repeated; bubbles ahead of the output keep
// moving whenever the output register is empty.
// Reset (synchronous, active low) clears all valid bits; payload registers
// are not reset and carry no meaning until their valid bit is set.
// ----------------------------------------------------------------------------
`default_nettype none
module point_triangle_closest_point (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert0_x,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert0_y,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert0_z,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert1_x,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert1_y,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert1_z,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert2_x,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert2_y,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_vert2_z,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_query_x,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_query_y,
    input  wire logic signed [ptcp_pkg::COORD_BITS-1:0]  i_query_z,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic [ptcp_pkg::COORD_BITS-1:0]              o_distance,
    output logic signed [ptcp_pkg::COORD_BITS-1:0]       o_closest_x,
    output logic signed [ptcp_pkg::COORD_BITS-1:0]       o_closest_y,
    output logic signed [ptcp_pkg::COORD_BITS-1:0]       o_closest_z,
    output logic                                         o_degenerate
);
    localparam int CB  = ptcp_pkg::COORD_BITS;
    localparam int EW  = ptcp_pkg::EW;
    localparam int SW  = ptcp_pkg::SUM_W;
    localparam int W   = ptcp_pkg::WIDE_W;
    localparam int QW  = ptcp_pkg::Q_W;
    localparam int PPW = QW + 1 + EW;
    localparam int AW  = PPW + 1;
    localparam int LD  = ptcp_pkg::LAT_DIV;
    localparam int LS  = ptcp_pkg::LAT_SQRT;
    localparam int LT  = ptcp_pkg::LAT_TOTAL;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (ptcp_pkg::SFRAC - 1);

    typedef struct packed {
        logic [2:0][CB-1:0] cl;
        logic               degen;
    } t_clq;

    // Pipeline control: one enable for every stage, valid bits alongside.
    logic          en;
    logic [LT-1:0] r_vld;

    assign en      = !r_vld[LT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LT-2:0], i_valid};
        end
    end

    // Front end: edges, dot products, det, s' and t'.
    ptcp_pkg::t_front fc;

    ptcp_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_v0    ({i_vert0_z, i_vert0_y, i_vert0_x}),
        .i_v1    ({i_vert1_z, i_vert1_y, i_vert1_x}),
        .i_v2    ({i_vert2_z, i_vert2_y, i_vert2_x}),
        .i_q     ({i_query_z, i_query_y, i_query_x}),
        .o_front (fc)
    );

    // First region stage: all the sign tests and edge-projection terms.
    logic signed [W:0]  n_stsum;
    logic signed [SW-1:0] n_t0a, n_t1a, n_t0b, n_t1b;

    logic               r1_le, r1_sn_neg, r1_tn_neg, r1_d_neg, r1_det_le0;
    logic               r1_lt_a, r1_t1a_le0, r1_lt_b, r1_t1b_le0;
    logic signed [SW-1:0] r1_numa, r1_numb, r1_den2, r1_a, r1_c, r1_nd, r1_ne;
    logic signed [W-1:0]  r1_sn, r1_tn, r1_det;

    always_comb begin
        n_stsum = (W+1)'($signed(fc.sn)) + (W+1)'($signed(fc.tn));
        n_t0a   = SW'($signed(fc.dots.b)) + SW'($signed(fc.dots.d));
        n_t1a   = SW'($signed(fc.dots.c)) + SW'($signed(fc.dots.e));
        n_t0b   = SW'($signed(fc.dots.b)) + SW'($signed(fc.dots.e));
        n_t1b   = SW'($signed(fc.dots.a)) + SW'($signed(fc.dots.d));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_le      <= n_stsum <= (W+1)'($signed(fc.det));
            r1_sn_neg  <= fc.sn[W-1];
            r1_tn_neg  <= fc.tn[W-1];
            r1_d_neg   <= fc.dots.d[ptcp_pkg::DOT_W-1];
            r1_det_le0 <= fc.det[W-1] || (fc.det == '0);
            r1_lt_a    <= n_t0a < n_t1a;
            r1_t1a_le0 <= n_t1a[SW-1] || (n_t1a == '0);
            r1_lt_b    <= n_t0b < n_t1b;
            r1_t1b_le0 <= n_t1b[SW-1] || (n_t1b == '0);
            r1_numa    <= n_t1a - n_t0a;
            r1_numb    <= n_t1b - n_t0b;
            r1_den2    <= SW'($signed(fc.dots.a)) - (SW'($signed(fc.dots.b)) <<< 1)
                        + SW'($signed(fc.dots.c));
            r1_a       <= SW'($signed(fc.dots.a));
            r1_c       <= SW'($signed(fc.dots.c));
            r1_nd      <= SW'(0) - SW'($signed(fc.dots.d));
            r1_ne      <= SW'(0) - SW'($signed(fc.dots.e));
            r1_sn      <= fc.sn;
            r1_tn      <= fc.tn;
            r1_det     <= fc.det;
        end
    end

    // Second region stage: pick the seven-region clamp. Divider S serves
    // every ratio that defines s, divider T every ratio that defines t.
    ptcp_pkg::t_ctl      n_ctl, r2_ctl;
    logic signed [W-1:0] n_nums, n_dens, n_numt, n_dent;
    logic signed [W-1:0] r2_nums, r2_dens, r2_numt, r2_dent;

    always_comb begin
        n_ctl.src_s = ptcp_pkg::SRC_ZERO;
        n_ctl.src_t = ptcp_pkg::SRC_ZERO;
        n_ctl.degen = 1'b0;
        n_nums      = W'(r1_nd);
        n_dens      = W'(r1_a);
        n_numt      = W'(r1_ne);
        n_dent      = W'(r1_c);
        if (r1_le) begin
            if (r1_sn_neg && r1_tn_neg) begin
                if (r1_d_neg) begin
                    n_ctl.src_s = ptcp_pkg::SRC_DIV;
                end else begin
                    n_ctl.src_t = ptcp_pkg::SRC_DIV;
                end
            end else if (r1_sn_neg) begin
                n_ctl.src_t = ptcp_pkg::SRC_DIV;
            end else if (r1_tn_neg) begin
                n_ctl.src_s = ptcp_pkg::SRC_DIV;
            end else if (r1_det_le0) begin
                // Coincident or collinear vertices: stay at vert0.
                n_ctl.degen = 1'b1;
            end else begin
                n_ctl.src_s = ptcp_pkg::SRC_DIV;
                n_ctl.src_t = ptcp_pkg::SRC_DIV;
                n_nums      = r1_sn;
                n_dens      = r1_det;
                n_numt      = r1_tn;
                n_dent      = r1_det;
            end
        end else if (r1_sn_neg) begin
            if (r1_lt_a) begin
                n_ctl.src_s = ptcp_pkg::SRC_DIV;
                n_ctl.src_t = ptcp_pkg::SRC_COMP;
                n_nums      = W'(r1_numa);
                n_dens      = W'(r1_den2);
            end else if (r1_t1a_le0) begin
                n_ctl.src_t = ptcp_pkg::SRC_ONE;
            end else begin
                n_ctl.src_t = ptcp_pkg::SRC_DIV;
            end
        end else if (r1_tn_neg) begin
            if (r1_lt_b) begin
                n_ctl.src_t = ptcp_pkg::SRC_DIV;
                n_ctl.src_s = ptcp_pkg::SRC_COMP;
                n_numt      = W'(r1_numb);
                n_dent      = W'(r1_den2);
            end else if (r1_t1b_le0) begin
                n_ctl.src_s = ptcp_pkg::SRC_ONE;
            end else begin
                n_ctl.src_s = ptcp_pkg::SRC_DIV;
            end
        end else begin
            // Beyond the edge V1-V2: project onto it.
            n_ctl.src_s = ptcp_pkg::SRC_DIV;
            n_ctl.src_t = ptcp_pkg::SRC_COMP;
            n_nums      = W'(r1_numa);
            n_dens      = W'(r1_den2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctl  <= n_ctl;
            r2_nums <= n_nums;
            r2_dens <= n_dens;
            r2_numt <= n_numt;
            r2_dent <= n_dent;
        end
    end

    // Fraction dividers, with control and geometry delayed alongside.
    logic [QW-1:0]      qs, qt;
    ptcp_pkg::t_ctl     r_ctl_d [LD];
    ptcp_pkg::t_geo     r_geo_d [LD+2];

    ptcp_div u_div_s (.i_clk(i_clk), .i_en(en), .i_num(r2_nums), .i_den(r2_dens), .o_q(qs));
    ptcp_div u_div_t (.i_clk(i_clk), .i_en(en), .i_num(r2_numt), .i_den(r2_dent), .o_q(qt));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo_d[0] <= fc.geo;
            for (int i = 1; i < LD + 2; i++) begin
                r_geo_d[i] <= r_geo_d[i-1];
            end
            r_ctl_d[0] <= r2_ctl;
            for (int i = 1; i < LD; i++) begin
                r_ctl_d[i] <= r_ctl_d[i-1];
            end
        end
    end

    // Final parameters s and t.
    ptcp_pkg::t_ctl ctl_q;
    logic [QW-1:0]  n_s, n_t;

    assign ctl_q = r_ctl_d[LD-1];

    always_comb begin
        case (ctl_q.src_s)
            ptcp_pkg::SRC_ONE:  n_s = ptcp_pkg::ONE_FR;
            ptcp_pkg::SRC_DIV:  n_s = qs;
            ptcp_pkg::SRC_COMP: n_s = ptcp_pkg::ONE_FR - qt;
            default:            n_s = '0;
        endcase
        case (ctl_q.src_t)
            ptcp_pkg::SRC_ONE:  n_t = ptcp_pkg::ONE_FR;
            ptcp_pkg::SRC_DIV:  n_t = qt;
            ptcp_pkg::SRC_COMP: n_t = ptcp_pkg::ONE_FR - qs;
            default:            n_t = '0;
        endcase
    end

    logic [QW-1:0]        r_c1_s, r_c1_t;
    ptcp_pkg::t_geo       r_c1_geo, r_c2_geo, r_c3_geo;
    logic                 r_c1_dg, r_c2_dg, r_c3_dg, r_c4_dg, r_c5_dg, r_c6_dg;
    logic signed [PPW-1:0] r_c2_p0 [3];
    logic signed [PPW-1:0] r_c2_p1 [3];
    logic signed [AW-1:0]  r_c3_acc [3];
    logic signed [AW-1:0]  n_off [3];
    logic signed [EW-1:0]  n_clw [3];
    logic [2:0][CB-1:0]    n_cl, r_c4_cl, r_c5_cl, r_c6_cl;
    logic signed [EW-1:0]  r_c4_diff [3];
    logic signed [ptcp_pkg::PROD_W-1:0] r_c5_sq [3];
    logic [ptcp_pkg::SUMSQ_W-1:0] r_c6_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_off[k] = r_c3_acc[k] >>> ptcp_pkg::SFRAC;
            n_clw[k] = $signed(r_c3_geo.v0[k]) + EW'(n_off[k]);
            n_cl[k]  = n_clw[k][CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_s   <= n_s;
            r_c1_t   <= n_t;
            r_c1_geo <= r_geo_d[LD+1];
            r_c1_dg  <= ctl_q.degen;

            for (int k = 0; k < 3; k++) begin
                r_c2_p0[k] <= $signed({1'b0, r_c1_s}) * $signed(r_c1_geo.e0[k]);
                r_c2_p1[k] <= $signed({1'b0, r_c1_t}) * $signed(r_c1_geo.e1[k]);
            end
            r_c2_geo <= r_c1_geo;
            r_c2_dg  <= r_c1_dg;

            for (int k = 0; k < 3; k++) begin
                r_c3_acc[k] <= AW'(r_c2_p0[k]) + AW'(r_c2_p1[k]) + HALF;
            end
            r_c3_geo <= r_c2_geo;
            r_c3_dg  <= r_c2_dg;

            for (int k = 0; k < 3; k++) begin
                r_c4_diff[k] <= EW'($signed(n_cl[k])) - $signed(r_c3_geo.q[k]);
            end
            r_c4_cl <= n_cl;
            r_c4_dg <= r_c3_dg;

            for (int k = 0; k < 3; k++) begin
                r_c5_sq[k] <= r_c4_diff[k] * r_c4_diff[k];
            end
            r_c5_cl <= r_c4_cl;
            r_c5_dg <= r_c4_dg;

            r_c6_sum <= ptcp_pkg::SUMSQ_W'($unsigned(r_c5_sq[0]))
                      + ptcp_pkg::SUMSQ_W'($unsigned(r_c5_sq[1]))
                      + ptcp_pkg::SUMSQ_W'($unsigned(r_c5_sq[2]));
            r_c6_cl  <= r_c5_cl;
            r_c6_dg  <= r_c5_dg;
        end
    end

    // Distance, with the closest point delayed to meet it.
    logic [CB-1:0] root;
    t_clq          r_cl_d [LS];

    ptcp_sqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_sum(r_c6_sum), .o_root(root));

    logic [CB-1:0]      r_o_dist;
    logic [2:0][CB-1:0] r_o_cl;
    logic               r_o_dg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl_d[0].cl    <= r_c6_cl;
            r_cl_d[0].degen <= r_c6_dg;
            for (int i = 1; i < LS; i++) begin
                r_cl_d[i] <= r_cl_d[i-1];
            end
            r_o_dist <= root;
            r_o_cl   <= r_cl_d[LS-1].cl;
            r_o_dg   <= r_cl_d[LS-1].degen;
        end
    end

    assign o_distance   = r_o_dist;
    assign o_closest_x  = $signed(r_o_cl[0]);
    assign o_closest_y  = $signed(r_o_cl[1]);
    assign o_closest_z  = $signed(r_o_cl[2]);
    assign o_degenerate = r_o_dg;
endmodule
`default_nettype wire

// ===== src/ptcp_chk.sv =====
// ----------------------------------------------------------------------------
// ptcp_chk: port-level checker for the closest-point block
// Watches the handshakes at the top level ports and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none
module ptcp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_distance,
    input wire logic [31:0] o_closest_x,
    input wire logic [31:0] o_closest_y,
    input wire logic [31:0] o_closest_z,
    input wire logic        o_degenerate
);
    // A result held back by the receiver stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance) && $stable(o_closest_x)
            && $stable(o_closest_y) && $stable(o_closest_z) && $stable(o_degenerate))
        else $error("result changed while stalled");

    // The input side is ready exactly when the pipeline moves.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow pipeline advance");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind point_triangle_closest_point ptcp_chk u_ptcp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_distance   (o_distance),
    .o_closest_x  (o_closest_x),
    .o_closest_y  (o_closest_y),
    .o_closest_z  (o_closest_z),
    .o_degenerate (o_degenerate)
);
`default_nettype wire

// ===== dv/point_triangle_closest_point_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_triangle_closest_point_tb: self-checking bench for the closest point
// Drives a short table of hand-made triangles and queries, then several
// hundred random items, with random gaps and output stalls on both sides.
// An exact wide-integer model predicts each result not pinned by hand;
// results are compared field by field, in order.
// ----------------------------------------------------------------------------
module point_triangle_closest_point_tb;
    localparam int                 NCRD     = 12;
    localparam int                 N_RANDOM = 480;
    localparam logic signed [31:0] U        = 32'sd65536;   // 1.0 in Q16.16
    localparam logic [63:0]        FULL     = 64'd1 << ptcp_pkg::SFRAC;

    // Every intermediate fits comfortably in 256 signed bits.
    typedef logic signed [255:0] t_wint;
    typedef logic signed [ptcp_pkg::COORD_BITS-1:0] t_crd;
    typedef t_crd t_crd_set [NCRD];

    typedef struct {
        logic [ptcp_pkg::COORD_BITS-1:0] dist_val;
        t_crd                            cx;
        t_crd                            cy;
        t_crd                            cz;
        logic                            degen;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_degenerate;
    logic [ptcp_pkg::COORD_BITS-1:0] o_distance;
    t_crd o_closest_x, o_closest_y, o_closest_z;
    t_crd coord [NCRD];

    t_answer answers_due [$];
    int      n_bad = 0;
    bit      idle_on = 1'b1;   // cleared for stretches of full-rate traffic

    initial begin
        for (int k = 0; k < NCRD; k++) coord[k] = '0;
    end

    always #5 i_clk = ~i_clk;

    point_triangle_closest_point uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_vert0_x(coord[0]), .i_vert0_y(coord[1]), .i_vert0_z(coord[2]),
        .i_vert1_x(coord[3]), .i_vert1_y(coord[4]), .i_vert1_z(coord[5]),
        .i_vert2_x(coord[6]), .i_vert2_y(coord[7]), .i_vert2_z(coord[8]),
        .i_query_x(coord[9]), .i_query_y(coord[10]), .i_query_z(coord[11]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_distance(o_distance), .o_closest_x(o_closest_x),
        .o_closest_y(o_closest_y), .o_closest_z(o_closest_z),
        .o_degenerate(o_degenerate)
    );

    // ------------------------------------------------------------------------
    // Predictor. All arithmetic is on the raw integers and is exact, so every
    // region decision matches the block bit for bit.
    // ------------------------------------------------------------------------

    // Clamped parameter num/den as a fraction with SFRAC fraction bits.
    function automatic logic [63:0] clamp_frac(t_wint num, t_wint den);
        t_wint q;
        if (num <= 0) return 64'd0;
        if (num >= den) return FULL;
        q = (num <<< ptcp_pkg::SFRAC) / den;
        return q[63:0];
    endfunction

    // Floor square root, saturating at the largest distance code.
    function automatic logic [ptcp_pkg::COORD_BITS-1:0] floor_root(t_wint sum);
        t_wint                           cw;
        logic [ptcp_pkg::COORD_BITS-1:0] res;
        logic [ptcp_pkg::COORD_BITS-1:0] cand;
        t_wint                           lim;
        lim = t_wint'(1) <<< (2 * ptcp_pkg::COORD_BITS);
        if (sum >= lim) return '1;
        res = '0;
        for (int bitn = ptcp_pkg::COORD_BITS - 1; bitn >= 0; bitn--) begin
            cand = res | (ptcp_pkg::COORD_BITS'(1) << bitn);
            cw = '0;
            cw[ptcp_pkg::COORD_BITS-1:0] = cand;
            if (cw * cw <= sum) res = cand;
        end
        return res;
    endfunction

    function automatic t_answer closest_on_triangle(t_crd_set c);
        t_wint       v0 [3], e0 [3], e1 [3], qp [3], dv [3];
        t_wint       a, b, c2, d, e, det, sn, tn, den2, t0, t1, acc, diff, sum, sw, tw;
        logic [63:0] s_par, t_par;
        t_answer     r;
        s_par = '0;
        t_par = '0;
        r.degen = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v0[k] = c[k];
            e0[k] = c[3 + k];
            e1[k] = c[6 + k];
            qp[k] = c[9 + k];
            e0[k] = e0[k] - v0[k];
            e1[k] = e1[k] - v0[k];
            dv[k] = v0[k] - qp[k];
        end
        a  = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
        b  = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
        c2 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
        d  = e0[0] * dv[0] + e0[1] * dv[1] + e0[2] * dv[2];
        e  = e1[0] * dv[0] + e1[1] * dv[1] + e1[2] * dv[2];
        det  = a * c2 - b * b;
        sn   = b * e - c2 * d;
        tn   = b * d - a * e;
        den2 = a - 2 * b + c2;

        if (sn + tn <= det) begin
            if (sn < 0 && tn < 0) begin
                // Behind the first vertex; region four keeps t = 0 when e >= 0.
                if (d < 0) s_par = clamp_frac(-d, a);
                else       t_par = clamp_frac(-e, c2);
            end else if (sn < 0) begin
                t_par = clamp_frac(-e, c2);
            end else if (tn < 0) begin
                s_par = clamp_frac(-d, a);
            end else if (det <= 0) begin
                // A flat triangle always lands here: the answer is vertex 0.
                r.degen = 1'b1;
            end else begin
                s_par = clamp_frac(sn, det);
                t_par = clamp_frac(tn, det);
            end
        end else if (sn < 0) begin
            t0 = b + d;
            t1 = c2 + e;
            if (t0 < t1) begin
                s_par = clamp_frac(t1 - t0, den2);
                t_par = FULL - s_par;
            end else if (t1 <= 0) t_par = FULL;
            else                  t_par = clamp_frac(-e, c2);
        end else if (tn < 0) begin
            // Region six projects onto the edge from vertex 1 to vertex 2 or onto the edge from vertex 0 to vertex 1.
            t0 = b + e;
            t1 = a + d;
            if (t0 < t1) begin
                t_par = clamp_frac(t1 - t0, den2);
                s_par = FULL - t_par;
            end else if (t1 <= 0) s_par = FULL;
            else                  s_par = clamp_frac(-d, a);
        end else begin
            s_par = clamp_frac((c2 + e) - (b + d), den2);
            t_par = FULL - s_par;
        end

        sw = '0;
        tw = '0;
        sw[63:0] = s_par;
        tw[63:0] = t_par;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            acc = sw * e0[k] + tw * e1[k] + (t_wint'(1) <<< (ptcp_pkg::SFRAC - 1));
            acc = (acc >>> ptcp_pkg::SFRAC) + v0[k];
            diff = acc - qp[k];
            sum = sum + diff * diff;
            if (k == 0) r.cx = acc[ptcp_pkg::COORD_BITS-1:0];
            if (k == 1) r.cy = acc[ptcp_pkg::COORD_BITS-1:0];
            if (k == 2) r.cz = acc[ptcp_pkg::COORD_BITS-1:0];
        end
        r.dist_val = floor_root(sum);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Each item waits a random gap (none while idle_on is clear), then
    // valid is held with a steady payload until the block takes it. The
    // expectation is queued on acceptance.
    // ------------------------------------------------------------------------
    bit      pin_next;
    t_answer pinned;

    task automatic send_item(t_crd_set c);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < NCRD; k++) coord[k] <= c[k];
        do @(posedge i_clk); while (!o_ready);
        if (pin_next) answers_due.push_back(pinned);
        else          answers_due.push_back(closest_on_triangle(c));
        // valid stays high for the next item unless the next gap lowers it
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls on i_ready and an in-order field check.
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected item dist=%h closest=%h %h %h deg=%b",
                             o_distance, o_closest_x, o_closest_y, o_closest_z,
                             o_degenerate);
            end else begin
                want = answers_due.pop_front();
                if (o_distance !== want.dist_val || o_closest_x !== want.cx ||
                    o_closest_y !== want.cy || o_closest_z !== want.cz ||
                    o_degenerate !== want.degen) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("ERROR: item mismatch at %0t\n  exp dist=%h pt=%h %h %h deg=%b\n  got dist=%h pt=%h %h %h deg=%b",
                                 $realtime, want.dist_val, want.cx, want.cy, want.cz,
                                 want.degen, o_distance, o_closest_x, o_closest_y,
                                 o_closest_z, o_degenerate);
                end
            end
            stall_left = idle_on ? $urandom_range(0, 19) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_ready <= (stall_left == 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    function automatic t_crd rand_crd(int mode);
        case (mode)
            0:       return t_crd'($urandom_range(0, 8 << 16)) - (t_crd'(4) <<< 16);
            1:       return t_crd'($urandom);
            default: return t_crd'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    task automatic run_table();
        t_crd_set row;
        t_crd     tri_k [9];
        t_crd     probe [8][3];
        // Right triangle of side 4 in the z = 0 plane, probed in each region.
        tri_k = '{0, 0, 0, 4 * U, 0, 0, 0, 4 * U, 0};
        probe = '{'{U, U, 3 * U},      // inside, above the face
                  '{3 * U, 3 * U, U},   // beyond the long edge
                  '{-U, 6 * U, 0},      // past vertex 2
                  '{-U, 2 * U, 0},      // beside the edge from vertex 0 to 2
                  '{-U, -U, 0},         // behind vertex 0
                  '{2 * U, -U, 0},      // beside the edge from vertex 0 to 1
                  '{6 * U, -U, 0},      // past vertex 1
                  '{0, 0, 0}};          // on vertex 0 itself
        pin_next = 1'b0;
        for (int p = 0; p < 8; p++) begin
            for (int k = 0; k < 9; k++) row[k] = tri_k[k];
            for (int k = 0; k < 3; k++) row[9 + k] = probe[p][k];
            if (p == 7) begin
                pin_next = 1'b1;
                pinned = '{dist_val: '0, cx: 0, cy: 0, cz: 0, degen: 1'b0};
            end
            send_item(row);
            pin_next = 1'b0;
        end

        // Point triangle at the origin queried at the origin.
        pin_next = 1'b1;
        pinned = '{dist_val: '0, cx: 0, cy: 0, cz: 0, degen: 1'b1};
        for (int k = 0; k < NCRD; k++) row[k] = 0;
        send_item(row);
        // All vertices at the top of the range, query at the bottom: flat
        // triangle and a saturated distance.
        pinned = '{dist_val: '1, cx: 32'h7fffffff, cy: 32'h7fffffff, cz: 32'h7fffffff,
                   degen: 1'b1};
        for (int k = 0; k < 9; k++) row[k] = 32'h7fffffff;
        for (int k = 9; k < NCRD; k++) row[k] = 32'h80000000;
        send_item(row);
        // And the mirror image.
        pinned = '{dist_val: '1, cx: 32'h80000000, cy: 32'h80000000, cz: 32'h80000000,
                   degen: 1'b1};
        for (int k = 0; k < 9; k++) row[k] = 32'h80000000;
        for (int k = 9; k < NCRD; k++) row[k] = 32'h7fffffff;
        send_item(row);
        pin_next = 1'b0;

        // Extreme-span triangles, checked against the predictor.
        row = '{32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0,
                32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        send_item(row);
        row = '{32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0,
                0, 32'h80000000, 32'h7fffffff, 0, 0, 0};
        send_item(row);
        // Collinear vertices with the query off the line.
        row = '{0, 0, 0, U, U, U, 2 * U, 2 * U, 2 * U, 5 * U, -3 * U, 7 * U};
        send_item(row);
        // Obtuse triangle: behind vertex 0 with d < 0.
        row = '{0, 0, 0, 4 * U, 0, 0, -4 * U, U, 0, 3 * U, -2 * U, U};
        send_item(row);
        // Alternating bit patterns in every field.
        for (int k = 0; k < NCRD; k++) row[k] = (k % 2) ? 32'h55555555 : 32'haaaaaaaa;
        send_item(row);
        for (int k = 0; k < NCRD; k++) row[k] = (k % 2) ? 32'haaaaaaaa : 32'h55555555;
        send_item(row);
    endtask

    task automatic run_random();
        t_crd_set row;
        int       mode, shape;
        for (int n = 0; n < N_RANDOM; n++) begin
            // Every so often run a stretch with neither side idling.
            if (n % 100 == 50) idle_on = 1'b0;
            if (n % 100 == 80) idle_on = 1'b1;
            shape = $urandom_range(0, 9);
            mode = (shape < 6) ? 0 : (shape < 8) ? 1 : 2;
            for (int k = 0; k < NCRD; k++) row[k] = rand_crd(mode);
            if (shape == 8) begin
                // Flat triangle when every axis picks alike: a repeated vertex or a collinear third vertex.
                for (int k = 0; k < 3; k++)
                    row[6 + k] = ($urandom_range(0, 1)) ? row[k] :
                                 row[3 + k] + (row[3 + k] - row[k]);
            end else if (shape == 9) begin
                // Query close to the face itself.
                for (int k = 0; k < 3; k++)
                    row[9 + k] = (row[k] + row[3 + k] + row[6 + k]) / 3 +
                                 t_crd'($urandom_range(0, 3)) - 1;
            end
            send_item(row);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_table();
        // Let the pipeline drain completely before the random traffic.
        go_quiet();
        while (answers_due.size() != 0) @(posedge i_clk);

        run_random();
        go_quiet();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (ptcp_pkg::LAT_TOTAL + 20) @(posedge i_clk);

        if (n_bad == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Slowest run: ~500 items with the longest random gaps and stalls plus drains.
    initial begin
        #5ms;
        $display("ERROR: timeout, %0d items still due", answers_due.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule
